// ===== rtl/core/cde_pkg.sv =====
// Shared types and constants for the circular deque engine.
package cde_pkg;

  localparam int unsigned CapW = 11;
  localparam int unsigned OutW = 32;
  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned DataWidthDefault = 32;
  localparam logic [CapW-1:0] CapReset = 11'd1024;

  typedef enum logic [2:0] {
    FUNC_INS_FRONT = 3'd0,
    FUNC_INS_REAR  = 3'd1,
    FUNC_DEL_FRONT = 3'd2,
    FUNC_DEL_REAR  = 3'd3,
    FUNC_QUERY     = 3'd4
  } cde_func_e;

  typedef struct packed {
    logic [2:0]          func;
    logic signed [31:0]  value;
  } cde_in_t;

  typedef struct packed {
    logic                accepted;
    logic signed [31:0]  front_value;
    logic signed [31:0]  rear_value;
    logic                is_empty;
    logic                is_full;
    logic [CapW-1:0]     occupancy;
  } cde_out_t;

  typedef struct packed {
    logic accepted;
    logic wr_en;
  } cde_upd_t;

endpackage

// ===== rtl/core/cde_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module cde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/cde_ctrl.sv =====
// Deque pointer unit: capacity register, head and tail indices and entry count.
module cde_ctrl #(
  parameter int unsigned DEPTH = cde_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cde_pkg::CapW-1:0]      cfg_data_i,
  input  logic                          step_i,
  input  logic [2:0]                    func_i,
  output cde_pkg::cde_upd_t             upd_o,
  output logic [$clog2(DEPTH)-1:0]      wr_addr_o,
  output logic [$clog2(DEPTH)-1:0]      rd_head_o,
  output logic [$clog2(DEPTH)-1:0]      rd_rear_o,
  output logic [cde_pkg::CapW-1:0]      count_o,
  output logic [cde_pkg::CapW-1:0]      eff_cap_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = cde_pkg::CapW;

  logic [CW-1:0] cap_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] eff_cap;
  logic [AW-1:0] head_n, tail_n;
  logic          full, empty;

  function automatic logic [AW-1:0] idx_inc(logic [AW-1:0] i, logic [CW-1:0] cap);
    logic [31:0] nxt;
    nxt = 32'(i) + 32'd1;
    return (nxt >= 32'(cap)) ? '0 : AW'(nxt);
  endfunction

  function automatic logic [AW-1:0] idx_dec(logic [AW-1:0] i, logic [CW-1:0] cap);
    return (i == '0 || 32'(i) > 32'(cap)) ? AW'(32'(cap) - 32'd1) : i - AW'(1);
  endfunction

  // Zero acts as one; anything above the store depth acts as the depth.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_q;
    end
  end

  assign head_n = (32'(head_q) >= 32'(eff_cap)) ? '0 : head_q;
  assign tail_n = (32'(tail_q) >= 32'(eff_cap)) ? '0 : tail_q;
  assign full   = count_q >= eff_cap;
  assign empty  = count_q == '0;

  always_comb begin
    head_d          = head_n;
    tail_d          = tail_n;
    count_d         = count_q;
    wr_addr_o       = tail_n;
    upd_o.accepted  = 1'b1;
    upd_o.wr_en     = 1'b0;
    case (func_i)
      cde_pkg::FUNC_INS_FRONT: begin
        if (full) begin
          upd_o.accepted = 1'b0;
        end else begin
          head_d      = idx_dec(head_n, eff_cap);
          wr_addr_o   = head_d;
          upd_o.wr_en = step_i;
          count_d     = count_q + CW'(1);
        end
      end
      cde_pkg::FUNC_INS_REAR: begin
        if (full) begin
          upd_o.accepted = 1'b0;
        end else begin
          tail_d      = idx_inc(tail_n, eff_cap);
          upd_o.wr_en = step_i;
          count_d     = count_q + CW'(1);
        end
      end
      cde_pkg::FUNC_DEL_FRONT: begin
        if (empty) begin
          upd_o.accepted = 1'b0;
        end else begin
          head_d  = idx_inc(head_n, eff_cap);
          count_d = count_q - CW'(1);
        end
      end
      cde_pkg::FUNC_DEL_REAR: begin
        if (empty) begin
          upd_o.accepted = 1'b0;
        end else begin
          tail_d  = idx_dec(tail_n, eff_cap);
          count_d = count_q - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= cde_pkg::CapReset;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      cap_q   <= cfg_data_i;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign rd_head_o = head_q;
  assign rd_rear_o = idx_dec(tail_q, eff_cap);
  assign count_o   = count_q;
  assign eff_cap_o = eff_cap;

endmodule

// ===== rtl/core/circular_deque_engine.sv =====
// Top level of the circular deque engine: sequencer, ring RAM and result register.
//
// Bounded double-ended queue of signed words kept in a ring RAM. Each input
// transaction passes the accept cycle, ST_RD and ST_RSP: the operation updates the
// pointers and writes the RAM in the accept cycle, the next cycle reads the front
// and rear entries through the RAM's two read ports, and ST_RSP loads the result
// register once the output register is free. The input stalls until that pass is
// over, so a new transaction is taken only after the last has loaded its result.
// A finished result may wait in the output register while the next is accepted.
// Capacity writes are taken only while the engine is idle and empty the deque.
module circular_deque_engine #(
  parameter int unsigned DEPTH      = cde_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = cde_pkg::DataWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [cde_pkg::CapW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  cde_pkg::cde_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output cde_pkg::cde_out_t        out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = cde_pkg::CapW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_RSP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic              in_accept, cfg_we, load_out;
  cde_pkg::cde_upd_t upd;
  logic [AW-1:0]     wr_addr, rd_head, rd_rear;
  logic [CW-1:0]     count, eff_cap;
  logic [DATA_WIDTH-1:0] wr_data, rd_front_data, rd_rear_data;
  logic              acc_q;
  logic              out_valid_q;
  cde_pkg::cde_out_t out_q, out_d;

  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = state_q == ST_IDLE;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign wr_data     = DATA_WIDTH'($signed(in_data_i.value));

  cde_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_accept),
    .func_i     (in_data_i.func),
    .upd_o      (upd),
    .wr_addr_o  (wr_addr),
    .rd_head_o  (rd_head),
    .rd_rear_o  (rd_rear),
    .count_o    (count),
    .eff_cap_o  (eff_cap)
  );

  cde_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (upd.wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_head),
    .raddr_b_i (rd_rear),
    .rdata_a_o (rd_front_data),
    .rdata_b_o (rd_rear_data)
  );

  // The read addresses hold steady while a result waits, so the RAM keeps
  // returning the same words until the output register frees up.
  assign load_out = (state_q == ST_RSP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_RSP;
      end
      ST_RSP: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d.accepted  = acc_q;
    out_d.is_empty  = count == '0;
    out_d.is_full   = count == eff_cap;
    out_d.occupancy = count;
    if (count == '0) begin
      out_d.front_value = -32'sd1;
      out_d.rear_value  = -32'sd1;
    end else begin
      out_d.front_value = 32'($signed(rd_front_data));
      out_d.rear_value  = 32'($signed(rd_rear_data));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      acc_q <= upd.accepted;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= eff_cap)
    else $error("entry count exceeds effective capacity");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_RD)
    else $error("accepted transaction did not start its RAM read");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd.wr_en |-> state_q == ST_IDLE)
    else $error("RAM written while a transaction is in flight");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |-> out_data_o.occupancy == '0)
    else $error("empty flag disagrees with occupancy");
`endif

endmodule
